FILE: hdl/lsfh_pkg.sv
// Shared types, constants and checksum helpers for the LIN slave frame handler.
`timescale 1ns / 1ps
`default_nettype none

package lsfh_pkg;

    // Frame geometry
    localparam int ID_COUNT_DEF   = 64;
    localparam int MAX_DATA_BYTES = 8;
    localparam int DATA_IDX_W     = $clog2(MAX_DATA_BYTES);
    localparam int FRAME_BUF_DEPTH = MAX_DATA_BYTES + 1;
    localparam int FRAME_IDX_W    = $clog2(FRAME_BUF_DEPTH);

    // Configuration port geometry: four registers, 64-bit data, 8-byte stride
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    // Register indexes (paddr[4:3])
    typedef enum logic [1:0] {
        REG_RX_ID_MASK    = 2'd0,
        REG_TX_ID_MASK    = 2'd1,
        REG_CHECKSUM_MODE = 2'd2,
        REG_LENGTH_MODE   = 2'd3
    } lsfh_reg_idx_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_RX    = 2'd1,
        KIND_ABORT = 2'd2
    } lsfh_kind_t;

    // Configuration seen by the frame engine
    typedef struct packed {
        logic [63:0] rx_id_mask;
        logic [63:0] tx_id_mask;
        logic        checksum_mode;
        logic        length_mode;
    } lsfh_cfg_t;

    // End-around carry byte add
    function automatic logic [7:0] oc_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 9'h0FF) begin
            s = s - 9'h0FF;
        end
        return s[7:0];
    endfunction

    // Data length from id bits five and four, or fixed eight
    function automatic logic [3:0] frame_len(input logic [5:0] id, input logic fixed8);
        logic [3:0] len;
        if (fixed8) begin
            len = 4'(MAX_DATA_BYTES);
        end else begin
            unique case (id[5:4] & 2'h3)
                2'd0:    len = 4'd2;
                2'd1:    len = 4'd2;
                2'd2:    len = 4'd4;
                default: len = 4'd8;
            endcase
        end
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lsfh_cfg_regs.sv
// APB-style configuration register file for the LIN slave frame handler.
`timescale 1ns / 1ps
`default_nettype none

module lsfh_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lsfh_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [lsfh_pkg::PDATA_W-1:0]   pwdata,
    output logic      [lsfh_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output lsfh_pkg::lsfh_cfg_t                 cfg
);

    lsfh_pkg::lsfh_reg_idx_t reg_idx;
    logic                    wr_en;
    lsfh_pkg::lsfh_cfg_t     cfg_reg;

    assign reg_idx = lsfh_pkg::lsfh_reg_idx_t'(paddr[4:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write on the access beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                lsfh_pkg::REG_RX_ID_MASK:    cfg_reg.rx_id_mask    <= pwdata;
                lsfh_pkg::REG_TX_ID_MASK:    cfg_reg.tx_id_mask    <= pwdata;
                lsfh_pkg::REG_CHECKSUM_MODE: cfg_reg.checksum_mode <= pwdata[0];
                lsfh_pkg::REG_LENGTH_MODE:   cfg_reg.length_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            lsfh_pkg::REG_RX_ID_MASK:    prdata = cfg_reg.rx_id_mask;
            lsfh_pkg::REG_TX_ID_MASK:    prdata = cfg_reg.tx_id_mask;
            lsfh_pkg::REG_CHECKSUM_MODE: prdata = {63'd0, cfg_reg.checksum_mode};
            lsfh_pkg::REG_LENGTH_MODE:   prdata = {63'd0, cfg_reg.length_mode};
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/lin_slave_frame_handler.sv
// LIN slave frame handler: a frame engine around a response store and a frame buffer.
//
// Input channel (s_*): one beat per received bus byte or per response store load.
// Store loads, flagged bytes and ordinary data bytes are handled in the idle state.
// Result channel (m_*): transmit bytes, received data bytes or an abort beat,
// held in an output register until taken.
// A transmit header reads the response store one byte at a time (ST_TX_RD, then
// ST_TX_PUT) and emits up to nine beats (data then checksum).
// A good receive checksum replays the frame buffer beat by beat (ST_RX_RD, ST_RX_PUT).
// An echoed byte is captured in ST_IDLE and compared against the frame buffer in
// ST_VF_CMP; a mismatch adds ST_ABORT for an abort beat. Both memories have a
// registered read; a read that meets a write to the same entry is never used.
// A stalled receiver holds the current beat and the sequencer waits on it;
// s_ready is low until the run finishes.
// Reset (aresetn, synchronous, active low) clears configuration, phase and the
// output valid flag; the memories are not cleared and need no clearing pass.
// Configuration is to be written only while no run is active; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module lin_slave_frame_handler #(
    parameter int ID_COUNT = lsfh_pkg::ID_COUNT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lsfh_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [lsfh_pkg::PDATA_W-1:0]   pwdata,
    output logic      [lsfh_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    // Input channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_cmd,
    input  wire logic [7:0]                     s_line_byte,
    input  wire logic                           s_header_flag,
    input  wire logic                           s_parity_error,
    input  wire logic                           s_frame_error,
    input  wire logic [5:0]                     s_load_id,
    input  wire logic [2:0]                     s_load_index,
    // Result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [1:0]                     m_kind,
    output logic      [7:0]                     m_out_byte,
    output logic      [5:0]                     m_frame_id,
    output logic      [3:0]                     m_byte_index,
    output logic                                m_last
);

    localparam int         STORE_DEPTH = ID_COUNT * lsfh_pkg::MAX_DATA_BYTES;
    localparam int         STORE_AW    = $clog2(STORE_DEPTH);
    localparam logic [6:0] ID_LIMIT    = 7'(ID_COUNT);
    localparam int         FIW         = lsfh_pkg::FRAME_IDX_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_TX_RD  = 8'b0000_0010,
        ST_TX_PUT = 8'b0000_0100,
        ST_TX_SUM = 8'b0000_1000,
        ST_RX_RD  = 8'b0001_0000,
        ST_RX_PUT = 8'b0010_0000,
        ST_VF_CMP = 8'b0100_0000,
        ST_ABORT  = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_IGNORE = 3'b001,
        PH_LISTEN = 3'b010,
        PH_VERIFY = 3'b100
    } phase_t;

    lsfh_pkg::lsfh_cfg_t cfg;

    lsfh_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Memories
    logic [7:0] store_mem [0:STORE_DEPTH-1];
    logic [7:0] fbuf_mem  [0:lsfh_pkg::FRAME_BUF_DEPTH-1];

    logic                store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic [STORE_AW-1:0] store_raddr;
    logic [7:0]          store_rdata_reg;

    logic                fbuf_we;
    logic [FIW-1:0]      fbuf_waddr;
    logic [7:0]          fbuf_wdata;
    logic [FIW-1:0]      fbuf_raddr;
    logic [7:0]          fbuf_rdata_reg;

    // Control and frame state
    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [7:0] pid_reg, pid_next;
    logic [3:0] len_reg, len_next;
    logic [3:0] rx_count_reg, rx_count_next;
    logic [3:0] verify_count_reg, verify_count_next;
    logic [3:0] idx_reg, idx_next;
    logic [7:0] acc_reg, acc_next;
    logic [7:0] echo_reg, echo_next;

    // Output register
    logic                 out_valid_reg;
    lsfh_pkg::lsfh_kind_t out_kind_reg;
    logic [7:0]           out_byte_reg;
    logic [5:0]           out_fid_reg;
    logic [3:0]           out_idx_reg;
    logic                 out_last_reg;

    logic                 out_load;
    lsfh_pkg::lsfh_kind_t out_kind;
    logic [7:0]           out_byte;
    logic [3:0]           out_idx;
    logic                 out_last;

    logic       s_accept;
    logic       out_free;
    logic [5:0] hdr_id;
    logic       hdr_id_ok;
    logic       load_id_ok;
    logic [7:0] sum_seed;
    logic [7:0] checksum;
    logic [3:0] idx_inc;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign out_free   = !out_valid_reg || m_ready;
    assign hdr_id     = s_line_byte[5:0] & 6'h3F;
    assign hdr_id_ok  = {1'b0, hdr_id} < ID_LIMIT;
    assign load_id_ok = {1'b0, s_load_id} < ID_LIMIT;
    assign sum_seed   = cfg.checksum_mode ? pid_reg : 8'h00;
    assign checksum   = ~lsfh_pkg::oc_add(acc_reg, sum_seed);
    assign idx_inc    = 4'(idx_reg + 4'd1);

    assign store_waddr = STORE_AW'({s_load_id, s_load_index});
    assign store_raddr = STORE_AW'({pid_reg[5:0], idx_reg[lsfh_pkg::DATA_IDX_W-1:0]});
    assign fbuf_raddr  = (state_reg == ST_IDLE) ? verify_count_reg[FIW-1:0]
                                                : idx_reg[FIW-1:0];

    // Sequencer
    always_comb begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        pid_next          = pid_reg;
        len_next          = len_reg;
        rx_count_next     = rx_count_reg;
        verify_count_next = verify_count_reg;
        idx_next          = idx_reg;
        acc_next          = acc_reg;
        echo_next         = echo_reg;
        store_we          = 1'b0;
        fbuf_we           = 1'b0;
        fbuf_waddr        = idx_reg[FIW-1:0];
        fbuf_wdata        = store_rdata_reg;
        out_load          = 1'b0;
        out_kind          = lsfh_pkg::KIND_TX;
        out_byte          = store_rdata_reg;
        out_idx           = idx_reg;
        out_last          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority if (s_cmd) begin
                        // load one response byte
                        store_we = load_id_ok;
                    end else if (s_parity_error || s_frame_error) begin
                        // drop flagged byte
                    end else if (s_header_flag) begin
                        // start a new frame
                        pid_next          = s_line_byte;
                        len_next          = lsfh_pkg::frame_len(hdr_id, cfg.length_mode);
                        rx_count_next     = 4'd0;
                        verify_count_next = 4'd0;
                        idx_next          = 4'd0;
                        acc_next          = 8'h00;
                        phase_next        = PH_IGNORE;
                        if (hdr_id_ok) begin
                            if (cfg.rx_id_mask[hdr_id]) begin
                                phase_next = PH_LISTEN;
                            end else if (cfg.tx_id_mask[hdr_id]) begin
                                phase_next = PH_VERIFY;
                                state_next = ST_TX_RD;
                            end
                        end
                    end else begin
                        unique case (phase_reg)
                            PH_LISTEN: begin
                                if (rx_count_reg < len_reg) begin
                                    // collect data byte, fold into sum
                                    fbuf_we       = 1'b1;
                                    fbuf_waddr    = rx_count_reg[FIW-1:0];
                                    fbuf_wdata    = s_line_byte;
                                    acc_next      = lsfh_pkg::oc_add(acc_reg, s_line_byte);
                                    rx_count_next = 4'(rx_count_reg + 4'd1);
                                end else begin
                                    // checksum byte: replay frame if good
                                    phase_next = PH_IGNORE;
                                    if (checksum == s_line_byte) begin
                                        idx_next   = 4'd0;
                                        state_next = ST_RX_RD;
                                    end
                                end
                            end
                            PH_VERIFY: begin
                                // capture echoed bus byte for comparison
                                echo_next  = s_line_byte;
                                state_next = ST_VF_CMP;
                            end
                            PH_IGNORE: ;
                            default: ;
                        endcase
                    end
                end
            end

            ST_TX_RD: begin
                state_next = ST_TX_PUT;
            end

            ST_TX_PUT: begin
                // emit response byte, keep a copy for echo check
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = lsfh_pkg::KIND_TX;
                    out_byte   = store_rdata_reg;
                    out_idx    = idx_reg;
                    fbuf_we    = 1'b1;
                    fbuf_waddr = idx_reg[FIW-1:0];
                    fbuf_wdata = store_rdata_reg;
                    acc_next   = lsfh_pkg::oc_add(acc_reg, store_rdata_reg);
                    idx_next   = idx_inc;
                    state_next = (idx_inc == len_reg) ? ST_TX_SUM : ST_TX_RD;
                end
            end

            ST_TX_SUM: begin
                // emit checksum as the last beat
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = lsfh_pkg::KIND_TX;
                    out_byte   = checksum;
                    out_idx    = len_reg;
                    out_last   = 1'b1;
                    fbuf_we    = 1'b1;
                    fbuf_waddr = len_reg[FIW-1:0];
                    fbuf_wdata = checksum;
                    state_next = ST_IDLE;
                end
            end

            ST_RX_RD: begin
                state_next = ST_RX_PUT;
            end

            ST_RX_PUT: begin
                // replay received data byte
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = lsfh_pkg::KIND_RX;
                    out_byte   = fbuf_rdata_reg;
                    out_idx    = idx_reg;
                    out_last   = (idx_inc == len_reg);
                    idx_next   = idx_inc;
                    state_next = (idx_inc == len_reg) ? ST_IDLE : ST_RX_RD;
                end
            end

            ST_VF_CMP: begin
                // compare echo with transmitted byte
                if (fbuf_rdata_reg == echo_reg) begin
                    verify_count_next = 4'(verify_count_reg + 4'd1);
                    if (verify_count_reg == len_reg) begin
                        phase_next = PH_IGNORE;
                    end
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_ABORT;
                end
            end

            ST_ABORT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = lsfh_pkg::KIND_ABORT;
                    out_byte   = echo_reg;
                    out_idx    = verify_count_reg;
                    out_last   = 1'b1;
                    phase_next = PH_IGNORE;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_IGNORE;
            pid_reg          <= 8'h00;
            len_reg          <= 4'd0;
            rx_count_reg     <= 4'd0;
            verify_count_reg <= 4'd0;
            idx_reg          <= 4'd0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            pid_reg          <= pid_next;
            len_reg          <= len_next;
            rx_count_reg     <= rx_count_next;
            verify_count_reg <= verify_count_next;
            idx_reg          <= idx_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        echo_reg <= echo_next;
    end

    // Response store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_waddr] <= s_line_byte;
        end
        store_rdata_reg <= store_mem[store_raddr];
    end

    // Frame buffer: received data or transmitted response plus checksum
    always_ff @(posedge aclk) begin
        if (fbuf_we) begin
            fbuf_mem[fbuf_waddr] <= fbuf_wdata;
        end
        fbuf_rdata_reg <= fbuf_mem[fbuf_raddr];
    end

    // Output register: hold beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_kind_reg <= out_kind;
            out_byte_reg <= out_byte;
            out_fid_reg  <= pid_reg[5:0];
            out_idx_reg  <= out_idx;
            out_last_reg <= out_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_frame_id   = out_fid_reg;
    assign m_byte_index = out_idx_reg;
    assign m_last       = out_last_reg;

endmodule

`default_nettype wire
